FILE: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg - shared types and constants for the stream find-and-replace block
// Register indexes, field widths and the source code of a drained result run.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 4;
    localparam int CFG_IDX_W = 3;

    // Defaults and limits
    localparam int MAX_PATTERN_BYTES = 8;
    localparam int MAX_REPL_BYTES    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;

    // Where the bytes after the held-prefix segment of a run come from
    typedef enum logic [1:0] {
        SRC_PAT,   // flushed pattern prefix
        SRC_REPL,  // replacement text
        SRC_CHAR,  // the input character itself
        SRC_NULL   // end-only marker, no character
    } t_src;

endpackage

`default_nettype wire

FILE: rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if - valid/ready channels of the stream find-and-replace block
// Input text beats, output text beats and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_in_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] text_byte;
    logic                       byte_present;
    logic                       text_end;

    modport source (output valid, text_byte, byte_present, text_end, input ready);
    modport sink   (input valid, text_byte, byte_present, text_end, output ready);
endinterface

interface sfr_out_if;
    logic                       valid;
    logic                       ready;
    logic [sfr_pkg::BYTE_W-1:0] out_byte;
    logic                       out_present;
    logic                       run_last;
    logic                       output_end;

    modport source (output valid, out_byte, out_present, run_last, output_end,
                    input ready);
    modport sink   (input valid, out_byte, out_present, run_last, output_end,
                    output ready);
endinterface

interface sfr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::CFG_IDX_W-1:0] index;
    logic [sfr_pkg::WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace - streaming substring find and replace
// Replaces every leftmost, non-overlapping occurrence of a pattern of up to
// MAX_PATTERN_BYTES bytes with a replacement of up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   i_text carries one text beat per item: a byte, a present flag and an end
//   flag. o_text returns the rewritten text, one byte per beat, with run_last
//   on the final beat an item causes and output_end on the final beat of the
//   whole text. An item with no byte and no end flag causes no beat.
//   i_cfg writes pattern, pattern length, replacement and replacement length
//   (indexes 0 to 3); other indexes are ignored. Write only while idle.
//   Writing the pattern or its length drops any held partial match.
// Timing:
//   An item waits in the input register, where its beats are planned, and
//   moves to the result register once that register is free, from which its
//   first beat is offered. Each item holds the result register until all its
//   beats (one to eight) are taken; an item with none never fills it. The
//   input register keeps taking items meanwhile until it is full, so items
//   of one beat each flow at one per cycle while o_text.ready stays high.
//   The result register drains through the single-byte output port.
// Reset and stall:
//   Reset clears the configuration, the valid flags, the beat position and
//   the match state; no input or write is taken while it is held. When the
//   receiver holds o_text.ready low the current beat holds, the result
//   register stays full and the input register then fills and drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace #(
    parameter int MAX_PATTERN_BYTES = sfr_pkg::MAX_PATTERN_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sfr_in_if.sink      i_text,
    sfr_cfg_if.sink     i_cfg,
    sfr_out_if.source   o_text
);

    localparam int P  = MAX_PATTERN_BYTES;
    localparam int IW = (P > 1) ? $clog2(P) : 1;
    localparam int BW = sfr_pkg::BYTE_W;
    localparam int LW = sfr_pkg::LEN_W;

    // Configuration registers
    logic [sfr_pkg::WORD_W-1:0] r_pattern;
    logic [LW-1:0]              r_plen;
    logic [sfr_pkg::WORD_W-1:0] r_repl;
    logic [LW-1:0]              r_rlen;

    // Input register
    logic          r_in_valid;
    logic [BW-1:0] r_in_byte;
    logic          r_in_present;
    logic          r_in_end;

    // Match state
    logic [LW-1:0] r_matched;

    // Result register: a run of prefix bytes followed by a second segment
    logic               r_ob_valid;
    logic [LW-1:0]      r_ob_a;
    logic [LW-1:0]      r_ob_n;
    logic [LW-1:0]      r_ob_pos;
    sfr_pkg::t_src      r_ob_src;
    logic [BW-1:0]      r_ob_char;
    logic               r_ob_end;

    // Plan for the item in the input register
    logic [LW-1:0]      n_a;
    logic [LW-1:0]      n_b;
    logic [LW-1:0]      n_n;
    sfr_pkg::t_src      n_src;
    logic [LW-1:0]      n_matched;
    logic               n_has_out;

    logic [LW-1:0]      w_plen;
    logic [LW-1:0]      w_rlen;
    logic [LW-1:0]      w_k;
    logic [IW-1:0]      w_kidx;
    logic [P-1:0]       w_bord [P];
    logic               w_found;
    logic [LW-1:0]      w_j;
    logic [LW-1:0]      w_nk;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_cfg_acc;
    logic               w_last;
    logic               w_ob_free;
    logic               w_load;
    logic [LW-1:0]      w_q;
    logic [2:0]         w_p3;
    logic [2:0]         w_q3;

    // Handshakes
    assign w_cfg_acc    = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready  = i_rst_n;
    assign w_in_acc     = i_text.valid && i_text.ready;
    assign w_out_acc    = o_text.valid && o_text.ready;
    assign w_last       = (r_ob_pos == r_ob_n - 1'b1);
    assign w_ob_free    = !r_ob_valid || (w_out_acc && w_last);
    assign w_load       = r_in_valid && w_ob_free;
    assign i_text.ready = i_rst_n && (!r_in_valid || w_load);

    // Saturated lengths
    assign w_plen = (r_plen > LW'(P)) ? LW'(P) : r_plen;
    assign w_rlen = (r_rlen > LW'(sfr_pkg::MAX_REPL_BYTES)) ?
                    LW'(sfr_pkg::MAX_REPL_BYTES) : r_rlen;

    // Held length, with a full match counted as nothing held
    assign w_k    = (r_matched >= w_plen) ? '0 : r_matched;
    assign w_kidx = w_k[IW-1:0];

    // Border table: pattern prefix of length jj ends the held prefix of length kk
    always_comb begin
        logic ok;
        for (int kk = 0; kk < P; kk++) begin
            w_bord[kk] = '0;
            for (int jj = 0; jj <= kk; jj++) begin
                ok = 1'b1;
                for (int ii = 0; ii < jj; ii++) begin
                    if (r_pattern[8*ii +: 8] != r_pattern[8*(kk-jj+ii) +: 8]) begin
                        ok = 1'b0;
                    end
                end
                w_bord[kk][jj] = ok;
            end
        end
    end

    // Longest fall-back that the new character extends
    always_comb begin
        w_found = 1'b0;
        w_j     = '0;
        for (int jj = 0; jj < P; jj++) begin
            if (LW'(jj) <= w_k && r_pattern[8*jj +: 8] == r_in_byte &&
                w_bord[w_kidx][jj]) begin
                w_found = 1'b1;
                w_j     = LW'(jj);
            end
        end
    end

    assign w_nk = w_j + 1'b1;

    // Result plan for one item
    always_comb begin
        n_a       = '0;
        n_b       = '0;
        n_src     = sfr_pkg::SRC_PAT;
        n_matched = r_matched;
        if (r_in_present) begin
            if (w_plen == '0) begin
                n_src     = sfr_pkg::SRC_CHAR;
                n_b       = LW'(1);
                n_matched = '0;
            end else if (w_found) begin
                n_a = w_k - w_j;
                if (w_nk == w_plen) begin
                    n_src     = sfr_pkg::SRC_REPL;
                    n_b       = w_rlen;
                    n_matched = '0;
                end else if (r_in_end) begin
                    n_src     = sfr_pkg::SRC_PAT;
                    n_b       = w_nk;
                    n_matched = '0;
                end else begin
                    n_matched = w_nk;
                end
            end else begin
                n_a       = w_k;
                n_src     = sfr_pkg::SRC_CHAR;
                n_b       = LW'(1);
                n_matched = '0;
            end
        end else if (r_in_end) begin
            // flush the held prefix
            n_a       = (r_matched < w_plen) ? r_matched : '0;
            n_matched = '0;
        end
        n_n = n_a + n_b;
        if (n_n == '0 && r_in_end) begin
            n_src = sfr_pkg::SRC_NULL;
            n_n   = LW'(1);
        end
        n_has_out = (n_n != '0);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= '0;
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (w_cfg_acc) begin
            unique case (i_cfg.index)
                sfr_pkg::CFG_PATTERN_BYTES:      r_pattern <= i_cfg.data;
                sfr_pkg::CFG_PATTERN_LENGTH:     r_plen    <= i_cfg.data[LW-1:0];
                sfr_pkg::CFG_REPLACEMENT_BYTES:  r_repl    <= i_cfg.data;
                sfr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg.data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte    <= i_text.text_byte;
            r_in_present <= i_text.byte_present;
            r_in_end     <= i_text.text_end;
        end
    end

    // Result register and match state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_valid <= 1'b0;
            r_ob_pos   <= '0;
            r_matched  <= '0;
        end else begin
            if (w_load) begin
                r_ob_valid <= n_has_out;
                r_ob_pos   <= '0;
            end else if (w_out_acc) begin
                if (w_last) begin
                    r_ob_valid <= 1'b0;
                end else begin
                    r_ob_pos <= r_ob_pos + 1'b1;
                end
            end
            // new pattern drops the held prefix
            if (w_cfg_acc && (i_cfg.index == sfr_pkg::CFG_PATTERN_BYTES ||
                              i_cfg.index == sfr_pkg::CFG_PATTERN_LENGTH)) begin
                r_matched <= '0;
            end else if (w_load) begin
                r_matched <= n_matched;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ob_a    <= n_a;
            r_ob_n    <= n_n;
            r_ob_src  <= n_src;
            r_ob_char <= r_in_byte;
            r_ob_end  <= r_in_end;
        end
    end

    // Output beat
    assign w_q  = r_ob_pos - r_ob_a;
    assign w_p3 = r_ob_pos[2:0];
    assign w_q3 = w_q[2:0];

    always_comb begin
        o_text.out_byte = '0;
        if (r_ob_pos < r_ob_a) begin
            o_text.out_byte = r_pattern[{w_p3, 3'b000} +: 8];
        end else begin
            case (r_ob_src)
                sfr_pkg::SRC_PAT:  o_text.out_byte = r_pattern[{w_q3, 3'b000} +: 8];
                sfr_pkg::SRC_REPL: o_text.out_byte = r_repl[{w_q3, 3'b000} +: 8];
                sfr_pkg::SRC_CHAR: o_text.out_byte = r_ob_char;
                default:           o_text.out_byte = '0;
            endcase
        end
    end

    assign o_text.valid       = r_ob_valid;
    assign o_text.out_present = (r_ob_src != sfr_pkg::SRC_NULL) || (r_ob_pos < r_ob_a);
    assign o_text.run_last    = w_last;
    assign o_text.output_end  = w_last && r_ob_end;

    // Checks
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_valid |-> (r_ob_n != '0 && r_ob_n <= LW'(8)))
        else $error("result run length out of range");

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_valid |-> (r_ob_pos < r_ob_n))
        else $error("beat position beyond run");

    a_held_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched < LW'(P))
        else $error("held prefix reached pattern size");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && w_last && !w_load) |=> !r_ob_valid)
        else $error("result register still full after last beat");

    a_null_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ob_valid && !o_text.out_present) |-> (o_text.run_last && o_text.output_end))
        else $error("end marker beat not alone at end of text");

endmodule

`default_nettype wire
